// ----- design/calibration_lut_gap_interpolation_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the calibration table block.
// ----------------------------------------------------------------------------
`ifndef CALIBRATION_LUT_GAP_INTERPOLATION_TOP_MACROS_SVH
`define CALIBRATION_LUT_GAP_INTERPOLATION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CLGI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CLGI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLGI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CLGI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/clgi_pkg.sv -----
// ----------------------------------------------------------------------------
// clgi_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package clgi_pkg;
  localparam int CHANNELS    = 6;
  localparam int TABLE_DEPTH = 4096;
  localparam int ENTRIES     = CHANNELS * TABLE_DEPTH;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OP_W        = 2;
  localparam int CHF_W       = 3;
  localparam int CODE_W      = 12;
  localparam int DAC_W       = 12;
  localparam int VOLT_W      = 17;
  localparam int ENTRY_W     = VOLT_W + 1;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int X_W         = DAC_W + 7;
  localparam int RECIP_W     = 20;
  localparam int MUL_W       = X_W + RECIP_W;
  localparam int RECIP_SH    = 22;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam int DIVC_W      = $clog2(VOLT_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_MARK   = 2'd1,
    OP_INTERP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic load_item;
    logic clr_start;
    logic clr_step;
    logic mul;
    logic mk_write;
    logic rd_item;
    logic scan_start;
    logic scan_rd;
    logic set_left;
    logic scan_next;
    logic div_start;
    logic fill_start;
    logic fill_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic mark_ok;
    logic clr_last;
    logic rd_valid;
    logic gap;
    logic j_last;
    logic ch_last;
    logic k_last;
    logic div_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/calibration_lut_gap_interpolation_top.sv -----
// ----------------------------------------------------------------------------
// calibration_lut_gap_interpolation_top
// Per-channel code-to-voltage table with mark, linear gap fill and read.
//
// Channel  Dir  tdata (low bit up)                           tuser
// in_      in   channel[2:0] code[14:3] dac_setting[26:15]   operation[1:0]
// out_     out  voltage[16:0]                                entry_valid
//
// Mark multiplies (S_MUL), writes (S_MKWR); read fetches (S_RD); clear writes
// all 24576 entries, one table entry per cycle; each hands its result to the
// output register (S_DONE). Interpolate reads (S_SCRD) and checks (S_SCCHK)
// each entry; a gap runs the divider (S_DIV), then fills the gap (S_FILL).
// After reset the same clear sweep runs before in_tready rises.
// One item at a time; a held result stalls the next item at its handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module calibration_lut_gap_interpolation_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // channel, code, dac_setting
  input  wire logic [clgi_pkg::IN_DATA_W-1:0]     in_tdata,
  // operation
  input  wire logic [clgi_pkg::OP_W-1:0]          in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // voltage
  output logic [clgi_pkg::OUT_DATA_W-1:0]         out_tdata,
  // entry_valid
  output logic                                    out_tuser
);
  import clgi_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  op_t               in_op;
  logic [VOLT_W-1:0] res_volt;

  assign in_op = op_t'(in_tuser);

  clgi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_op),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  clgi_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (in_op),
    .in_ch    (in_tdata[CHF_W-1:0]),
    .in_code  (in_tdata[CHF_W +: CODE_W]),
    .in_dac   (in_tdata[CHF_W+CODE_W +: DAC_W]),
    .res_volt (res_volt),
    .res_flag (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(res_volt);
endmodule
`default_nettype wire

// ----- design/clgi_div.sv -----
// ----------------------------------------------------------------------------
// clgi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module clgi_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [clgi_pkg::VOLT_W-1:0] dividend,
  input  wire logic [clgi_pkg::IDX_W-1:0]  divisor,
  output logic                             busy,
  output logic [clgi_pkg::VOLT_W-1:0]      quo,
  output logic [clgi_pkg::IDX_W-1:0]       rem
);
  import clgi_pkg::*;

  logic [VOLT_W-1:0] quo_r;
  logic [IDX_W-1:0]  rem_r;
  logic [IDX_W-1:0]  dvs_r;
  logic [DIVC_W-1:0] cnt_r;
  logic              busy_r;
  logic [IDX_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quo_r[VOLT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VOLT_W-2:0], fits};
      rem_r <= fits ? IDX_W'(trial - {1'b0, dvs_r}) : IDX_W'(trial);
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIVC_W'(VOLT_W - 1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ----- design/clgi_dpath.sv -----
// ----------------------------------------------------------------------------
// clgi_dpath
// Table memory, item registers, scan/fill counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module clgi_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire clgi_pkg::cmd_t               cmd,
  output clgi_pkg::sts_t                    sts,
  input  wire clgi_pkg::op_t                in_op,
  input  wire logic [clgi_pkg::CHF_W-1:0]   in_ch,
  input  wire logic [clgi_pkg::CODE_W-1:0]  in_code,
  input  wire logic [clgi_pkg::DAC_W-1:0]   in_dac,
  output logic [clgi_pkg::VOLT_W-1:0]       res_volt,
  output logic                              res_flag
);
  import clgi_pkg::*;

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRY_W-1:0] rdata_r;

  op_t               op_r;
  logic [CHF_W-1:0]  ch_item_r;
  logic [CODE_W-1:0] code_r;
  logic [DAC_W-1:0]  dac_r;
  logic [MUL_W-1:0]  prod_r;
  logic [ADDR_W-1:0] clr_ptr_r;
  logic [CH_W-1:0]   ch_r;
  logic [IDX_W-1:0]  j_r;
  logic [IDX_W-1:0]  left_r;
  logic [IDX_W-1:0]  k_r;
  logic              have_left_r;
  logic [VOLT_W-1:0] vleft_r;
  logic              neg_r;
  logic [VOLT_W-1:0] q_r;
  logic [IDX_W-1:0]  r_r;
  logic              rd_ok_r;
  logic [VOLT_W-1:0] res_volt_r;
  logic              res_flag_r;

  logic              in_range;
  logic [ADDR_W-1:0] item_addr;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] fill_addr;
  logic [X_W-1:0]    x96;
  logic [VOLT_W-1:0] vb;
  logic [VOLT_W-1:0] mag;
  logic [IDX_W-1:0]  span;
  logic [VOLT_W-1:0] dq;
  logic [IDX_W-1:0]  dr;
  logic [IDX_W:0]    r_sum;
  logic              r_wrap;
  logic [VOLT_W-1:0] fill_v;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENTRY_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  assign in_range  = (5'(ch_item_r) < 5'(CHANNELS)) && (17'(code_r) < 17'(TABLE_DEPTH));
  assign item_addr = ADDR_W'(ADDR_W'(ch_item_r) * ADDR_W'(TABLE_DEPTH)) + ADDR_W'(IDX_W'(code_r));
  assign scan_addr = ADDR_W'(ADDR_W'(ch_r) * ADDR_W'(TABLE_DEPTH)) + ADDR_W'(j_r);
  assign fill_addr = ADDR_W'(ADDR_W'(ch_r) * ADDR_W'(TABLE_DEPTH)) + ADDR_W'(k_r);
  assign x96       = (X_W'(dac_r) << 6) + (X_W'(dac_r) << 5);
  assign vb        = rdata_r[VOLT_W-1:0];
  assign mag       = (vb < vleft_r) ? (vleft_r - vb) : (vb - vleft_r);
  assign span      = j_r - left_r;
  assign r_sum     = {1'b0, r_r} + {1'b0, dr};
  assign r_wrap    = r_sum >= {1'b0, span};
  assign fill_v    = neg_r ? (vleft_r - q_r) : (vleft_r + q_r);

  clgi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (span),
    .busy     (sts.div_busy),
    .quo      (dq),
    .rem      (dr)
  );

  always_comb begin
    we    = 1'b0;
    waddr = clr_ptr_r;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.mk_write) begin
      we    = 1'b1;
      waddr = item_addr;
      wdata = {1'b1, prod_r[RECIP_SH +: VOLT_W]};
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = fill_addr;
      wdata = {1'b1, fill_v};
    end
    re    = cmd.scan_rd || (cmd.rd_item && in_range);
    raddr = cmd.scan_rd ? scan_addr : item_addr;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r   <= '0;
      have_left_r <= 1'b0;
      ch_r        <= '0;
      j_r         <= '0;
    end else begin
      if (cmd.clr_start) clr_ptr_r <= '0;
      else if (cmd.clr_step) clr_ptr_r <= clr_ptr_r + 1'b1;
      if (cmd.scan_start) begin
        ch_r        <= '0;
        j_r         <= '0;
        have_left_r <= 1'b0;
      end else begin
        if (cmd.set_left) have_left_r <= 1'b1;
        if (cmd.scan_next) begin
          j_r <= j_r + 1'b1;
          if (sts.j_last) begin
            ch_r        <= ch_r + 1'b1;
            have_left_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r      <= in_op;
      ch_item_r <= in_ch;
      code_r    <= in_code;
      dac_r     <= in_dac;
    end
    if (cmd.mul) prod_r <= MUL_W'(x96) * MUL_W'(RECIP);
    if (cmd.rd_item) rd_ok_r <= in_range;
    if (cmd.set_left) begin
      left_r  <= j_r;
      vleft_r <= vb;
    end
    if (cmd.div_start) neg_r <= vb < vleft_r;
    if (cmd.fill_start) begin
      k_r <= left_r + 1'b1;
      q_r <= dq;
      r_r <= dr;
    end else if (cmd.fill_step) begin
      k_r <= k_r + 1'b1;
      q_r <= q_r + dq + VOLT_W'(r_wrap);
      r_r <= r_wrap ? IDX_W'(r_sum - {1'b0, span}) : IDX_W'(r_sum);
    end
    if (cmd.res_load) begin
      if (op_r == OP_READ && rd_ok_r && rdata_r[VOLT_W]) begin
        res_volt_r <= vb;
        res_flag_r <= 1'b1;
      end else begin
        res_volt_r <= '0;
        res_flag_r <= 1'b0;
      end
    end
  end

  assign sts.mark_ok  = in_range && (code_r != '0);
  assign sts.clr_last = clr_ptr_r == ADDR_W'(ENTRIES - 1);
  assign sts.rd_valid = rdata_r[VOLT_W];
  assign sts.gap      = have_left_r && (span > IDX_W'(1));
  assign sts.j_last   = j_r == IDX_W'(TABLE_DEPTH - 1);
  assign sts.ch_last  = ch_r == CH_W'(CHANNELS - 1);
  assign sts.k_last   = k_r == (j_r - 1'b1);

  assign res_volt = res_volt_r;
  assign res_flag = res_flag_r;
endmodule
`default_nettype wire

// ----- design/clgi_ctrl.sv -----
// ----------------------------------------------------------------------------
// clgi_ctrl
// Sequencer: clear sweep, mark, read, scan/divide/fill, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "calibration_lut_gap_interpolation_top_macros.svh"
module clgi_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire clgi_pkg::op_t  in_op,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output clgi_pkg::cmd_t      cmd,
  input  wire clgi_pkg::sts_t sts
);
  import clgi_pkg::*;

  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_MKWR  = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_SCRD  = 10'b0000100000,
    S_SCCHK = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_FILL  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_res_r, clr_res_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   scan_end;

  assign out_free  = !out_valid_r || out_tready;
  assign scan_end  = sts.j_last && sts.ch_last;
  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    clr_res_nxt = clr_res_r;
    cmd         = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = clr_res_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          case (in_op)
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              clr_res_nxt   = 1'b1;
              state_nxt     = S_CLR;
            end
            OP_MARK:   state_nxt = S_MUL;
            OP_INTERP: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCRD;
            end
            OP_READ:   state_nxt = S_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MKWR;
      end
      S_MKWR: begin
        cmd.mk_write = sts.mark_ok;
        state_nxt    = S_DONE;
      end
      S_RD: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCRD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCCHK;
      end
      S_SCCHK: begin
        if (sts.rd_valid && sts.gap) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.set_left  = sts.rd_valid;
          cmd.scan_next = 1'b1;
          state_nxt     = scan_end ? S_DONE : S_SCRD;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.fill_start = 1'b1;
          state_nxt      = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.k_last) begin
          cmd.set_left  = 1'b1;
          cmd.scan_next = 1'b1;
          state_nxt     = scan_end ? S_DONE : S_SCRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          clr_res_nxt  = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.res_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `CLGI_ASSERT_IMP(a_fill_after_div, clk, rst_n, cmd.fill_step || cmd.fill_start, !sts.div_busy)
  `CLGI_ASSERT_NXT(a_div_starts, clk, rst_n, cmd.div_start, sts.div_busy)
  `CLGI_ASSERT_IMP(a_res_slot_free, clk, rst_n, cmd.res_load, out_free)
  `CLGI_ASSERT_NXT(a_res_shown, clk, rst_n, cmd.res_load, out_tvalid)
endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the per-channel calibration table: clear, mark, gap fill and
// read transfers are checked against an in-bench table model, first from a
// directed table, then with random items under varying idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
  import clgi_pkg::*;

  typedef struct {
    logic [VOLT_W-1:0] volt;
    logic              valid;
  } lut_result_t;

  typedef struct {
    op_t               op;
    logic [2:0]        ch;
    logic [11:0]       code;
    logic [11:0]       dac;
    bit                fixed;
    logic [VOLT_W-1:0] volt;
    logic              valid;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic [ENTRY_W-1:0] cal_lut [CHANNELS][TABLE_DEPTH];
  lut_result_t        pending_reads [$];
  int                 errors;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 hold_req;
  int                 n_mark, n_read, n_fill, n_clear;
  logic [11:0]        marked_codes [$];
  logic [2:0]         marked_chs [$];

  calibration_lut_gap_interpolation_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void lut_clear();
    for (int c = 0; c < CHANNELS; c++)
      for (int j = 0; j < TABLE_DEPTH; j++)
        cal_lut[c][j] = '0;
  endfunction

  function automatic void lut_fill_gaps();
    bit     have_left;
    int     left;
    longint va, vb, span, step;
    for (int c = 0; c < CHANNELS; c++) begin
      have_left = 0;
      left = 0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (!cal_lut[c][j][VOLT_W]) continue;
        if (have_left && j > left + 1) begin
          va = cal_lut[c][left][VOLT_W-1:0];
          vb = cal_lut[c][j][VOLT_W-1:0];
          span = j - left;
          for (int k = left + 1; k < j; k++) begin
            step = (longint'(k - left) * (vb - va)) / span;
            cal_lut[c][k] = {1'b1, VOLT_W'(va + step)};
          end
        end
        have_left = 1;
        left = j;
      end
    end
  endfunction

  function automatic lut_result_t lut_apply(op_t op, logic [2:0] ch, logic [11:0] code,
                                            logic [11:0] dac);
    lut_result_t r;
    bit          in_range;
    r.volt = '0;
    r.valid = 1'b0;
    in_range = (ch < CHANNELS) && (code < TABLE_DEPTH);
    case (op)
      OP_CLEAR: begin
        lut_clear();
        n_clear++;
      end
      OP_MARK: begin
        n_mark++;
        if (in_range && code > 0)
          cal_lut[ch][code] = {1'b1, VOLT_W'((32'(dac) * 96) / 5)};
      end
      OP_INTERP: begin
        lut_fill_gaps();
        n_fill++;
      end
      default: begin
        n_read++;
        if (in_range && cal_lut[ch][code][VOLT_W]) begin
          r.volt = cal_lut[ch][code][VOLT_W-1:0];
          r.valid = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(stim_row_t row);
    lut_result_t r;
    int          gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.op;
    in_tdata  <= {5'b0, row.dac, row.code, row.ch};
    do @(posedge clk); while (!in_tready);
    r = lut_apply(row.op, row.ch, row.code, row.dac);
    if (row.fixed) begin
      r.volt = row.volt;
      r.valid = row.valid;
    end
    pending_reads.push_back(r);
    if (row.op == OP_MARK) begin
      marked_codes.push_back(row.code);
      marked_chs.push_back(row.ch);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side: checks and stall generation
  initial begin
    lut_result_t e;
    int          hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_reads.size() == 0) begin
          $error("unexpected transfer: voltage %0d entry_valid %0d",
                 out_tdata[VOLT_W-1:0], out_tuser);
          errors++;
        end else begin
          e = pending_reads.pop_front();
          if (out_tdata[VOLT_W-1:0] !== e.volt) begin
            $error("voltage: expected %0d, got %0d", e.volt, out_tdata[VOLT_W-1:0]);
            errors++;
          end
          if (out_tuser !== e.valid) begin
            $error("entry_valid: expected %0d, got %0d", e.valid, out_tuser);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  stim_row_t directed [] = '{
    '{OP_CLEAR,  3'd0, 12'd0,    12'd0,    1, 17'd0,     1'b0},
    '{OP_READ,   3'd0, 12'd20,   12'd0,    1, 17'd0,     1'b0},
    '{OP_MARK,   3'd0, 12'd10,   12'd0,    1, 17'd0,     1'b0},
    '{OP_MARK,   3'd0, 12'd20,   12'd4095, 1, 17'd0,     1'b0},
    '{OP_READ,   3'd0, 12'd20,   12'd0,    1, 17'd78624, 1'b1},
    '{OP_READ,   3'd0, 12'd10,   12'd0,    1, 17'd0,     1'b1},
    '{OP_MARK,   3'd1, 12'd0,    12'd4095, 1, 17'd0,     1'b0},
    '{OP_READ,   3'd1, 12'd0,    12'd0,    1, 17'd0,     1'b0},
    '{OP_MARK,   3'd6, 12'd5,    12'd100,  1, 17'd0,     1'b0},
    '{OP_READ,   3'd6, 12'd5,    12'd0,    1, 17'd0,     1'b0},
    '{OP_MARK,   3'd7, 12'd4095, 12'd4095, 1, 17'd0,     1'b0},
    '{OP_READ,   3'd7, 12'd4095, 12'd4095, 1, 17'd0,     1'b0},
    '{OP_MARK,   3'd2, 12'd100,  12'd1234, 1, 17'd0,     1'b0},
    '{OP_MARK,   3'd5, 12'd4095, 12'd2048, 1, 17'd0,     1'b0},
    '{OP_MARK,   3'd5, 12'd4000, 12'd1,    1, 17'd0,     1'b0},
    '{OP_MARK,   3'd5, 12'd4000, 12'd4095, 1, 17'd0,     1'b0},
    '{OP_READ,   3'd5, 12'd4000, 12'd0,    1, 17'd78624, 1'b1},
    '{OP_READ,   3'd5, 12'd4095, 12'd0,    1, 17'd39321, 1'b1},
    '{OP_INTERP, 3'd0, 12'd0,    12'd0,    1, 17'd0,     1'b0},
    '{OP_READ,   3'd0, 12'd15,   12'd0,    0, 17'd0,     1'b0},
    '{OP_READ,   3'd0, 12'd9,    12'd0,    1, 17'd0,     1'b0},
    '{OP_READ,   3'd0, 12'd21,   12'd0,    1, 17'd0,     1'b0},
    '{OP_READ,   3'd2, 12'd101,  12'd0,    1, 17'd0,     1'b0},
    '{OP_READ,   3'd5, 12'd4050, 12'd0,    0, 17'd0,     1'b0},
    '{OP_READ,   3'd5, 12'd4095, 12'd0,    0, 17'd0,     1'b0}
  };

  initial begin
    stim_row_t row;
    int        pick, idx, fills_left, clears_left;
    errors = 0;
    n_mark = 0; n_read = 0; n_fill = 0; n_clear = 0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    lut_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i]);
    drain();

    fills_left = 3;
    clears_left = 1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int n = 0; n < 29; n++) begin
        if (phase == 0 && n == 5) hold_req = 1;
        row.fixed = 0;
        row.volt = '0;
        row.valid = 1'b0;
        row.dac = 12'($urandom_range(4095));
        row.ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                          : 3'($urandom_range(5));
        row.code = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 3 && fills_left > 0) begin
          row.op = OP_INTERP;
          fills_left--;
        end else if (pick == 3 && clears_left > 0) begin
          row.op = OP_CLEAR;
          clears_left--;
        end else if (pick < 50) begin
          row.op = OP_MARK;
          if (marked_codes.size() > 0 && $urandom_range(3) != 0) begin
            idx = $urandom_range(marked_codes.size() - 1);
            row.ch = marked_chs[idx];
            row.code = marked_codes[idx] + 12'($urandom_range(40));
          end
        end else begin
          row.op = OP_READ;
          if (marked_codes.size() > 0 && $urandom_range(4) != 0) begin
            idx = $urandom_range(marked_codes.size() - 1);
            row.ch = marked_chs[idx];
            row.code = marked_codes[idx] + 12'($urandom_range(6)) - 12'd3;
          end
        end
        send_item(row);
      end
      if (phase == 1 && fills_left > 0) begin
        row.op = OP_INTERP;
        fills_left--;
        send_item(row);
      end
      drain();
    end

    $display("Covered %0d marks, %0d reads, %0d gap fills, %0d clears",
             n_mark, n_read, n_fill, n_clear);
    $display("under idle, stall, long hold-off and drain phases");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
